/* rtl/nmea_chk_pkg.sv */
// Package with character codes, result codes and shared types of the NMEA sentence checker
`timescale 1ns / 1ps
package nmea_chk_pkg;

    // characters that steer the parse
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UC     = 8'h43;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_UG     = 8'h47;
    localparam logic [7:0] CH_UL     = 8'h4C;
    localparam logic [7:0] CH_UM     = 8'h4D;
    localparam logic [7:0] CH_UN     = 8'h4E;
    localparam logic [7:0] CH_UP     = 8'h50;
    localparam logic [7:0] CH_UR     = 8'h52;
    localparam logic [7:0] CH_US     = 8'h53;
    localparam logic [7:0] CH_UV     = 8'h56;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;

    // header is '$', two talker and three type characters
    localparam int unsigned HDR_LEN = 6;

    // field numbers holding the utc time and the date
    localparam logic [4:0] FIELD_TIME = 5'd1;
    localparam logic [4:0] FIELD_DATE = 5'd9;

    // range limits
    localparam logic [6:0] MAX_HOUR   = 7'd23;
    localparam logic [6:0] MAX_MINSEC = 7'd59;
    localparam logic [6:0] MAX_DAY    = 7'd31;
    localparam logic [6:0] MAX_MONTH  = 7'd12;
    localparam logic [6:0] YEAR_PIVOT = 7'd90;
    localparam logic [7:0] CENTURY    = 8'd100;

    typedef enum logic [2:0] {
        TYPE_UNKNOWN = 3'd0,
        TYPE_GGA     = 3'd1,
        TYPE_GSA     = 3'd2,
        TYPE_GSV     = 3'd3,
        TYPE_RMC     = 3'd4
    } t_sentence_type;

    typedef enum logic [1:0] {
        TALK_UNKNOWN = 2'd0,
        TALK_GP      = 2'd1,
        TALK_GL      = 2'd2,
        TALK_GN      = 2'd3
    } t_talker;

    typedef enum logic [2:0] {
        RSN_ACCEPTED     = 3'd0,
        RSN_BAD_HEADER   = 3'd1,
        RSN_TYPE_OFF     = 3'd2,
        RSN_NO_STAR      = 3'd3,
        RSN_BAD_CHECKSUM = 3'd4
    } t_reason;

    // time and date taken from the fields
    typedef struct packed {
        logic       t_ok;
        logic [4:0] hh;
        logic [5:0] mi;
        logic [5:0] ss;
        logic [9:0] ms;
        logic       d_ok;
        logic [4:0] dd;
        logic [3:0] mo;
        logic [7:0] yy;
    } t_stamp;

endpackage

/* rtl/nmea_sentence_checker.sv */
// Top level of the NMEA sentence checker: byte parser, checksum and verdict register
`timescale 1ns / 1ps
// Takes one sentence character per transfer and gives one verdict per sentence. A character
// is taken in every cycle unless a final character waits: it sits in an input register, one
// pass of parse logic updates the sentence state, and on the final character the verdict is
// loaded into an output register. Characters that produce no verdict keep flowing while a
// verdict waits downstream; only a final character waits for the output register to free up.
// The type_enable register should be written only with no sentence in flight.
module nmea_sentence_checker
    import nmea_chk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // character input
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    // configuration
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_type_enable,
    // verdict output
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_sentence_type,
    output logic [1:0] o_talker_id,
    output logic [2:0] o_reject_reason,
    output logic       o_time_ok,
    output logic [4:0] o_hour,
    output logic [5:0] o_minute,
    output logic [5:0] o_second,
    output logic [9:0] o_millisecond,
    output logic       o_date_ok,
    output logic [4:0] o_day,
    output logic [3:0] o_month,
    output logic [7:0] o_year
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_data;
    logic       r_last;

    // configuration
    logic [3:0] r_type_enable;

    // sentence state
    logic [2:0] r_pos,  n_pos;
    logic [7:0] r_hdr [HDR_LEN];
    logic [7:0] n_hdr [HDR_LEN];
    logic [7:0] r_xor,  n_xor;
    logic [7:0] r_xor_star, n_xor_star;
    logic       r_star, n_star;
    logic [1:0] r_cas,  n_cas;
    logic [7:0] r_rsum, n_rsum;
    logic       r_hex_ok, n_hex_ok;
    logic [4:0] r_fidx, n_fidx;
    logic [3:0] r_fcnt, n_fcnt;
    logic [6:0] r_pair [3];
    logic [6:0] n_pair [3];
    logic       r_pair_bad, n_pair_bad;
    logic       r_dot, n_dot;
    logic       r_frac_bad, n_frac_bad;
    logic [2:0] r_frac_len, n_frac_len;
    logic [9:0] r_frac_val, n_frac_val;
    t_stamp     r_commit, n_commit;
    t_stamp     r_at_star, n_at_star;

    // output register
    logic           r_out_valid;
    t_sentence_type r_type, n_type;
    t_talker        r_talk, n_talk;
    t_reason        r_reason, n_reason;
    t_stamp         r_res, n_res;

    // handshake
    logic out_free;
    logic advance;

    // per character decode
    logic       is_dig;
    logic [3:0] digit;
    logic       hex_good;
    logic [3:0] hex_val;
    logic [6:0] pair_cur;

    // verdict of the field in progress
    logic       cur_t_ok;
    logic [9:0] cur_ms;
    logic       cur_d_ok;
    logic [6:0] cur_mo;
    logic [7:0] cur_yy;
    logic       hdr_ok;
    logic       type_on;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && (!r_last || out_free);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    // hex digit of either case
    always_comb begin
        hex_good = 1'b1;
        hex_val  = 4'd0;
        if (r_data >= CH_0 && r_data <= CH_9) begin
            hex_val = r_data[3:0];
        end else if ((r_data >= CH_UA && r_data <= CH_UF)
                     || (r_data >= CH_LA && r_data <= CH_LF)) begin
            hex_val = r_data[3:0] + 4'd9;
        end else begin
            hex_good = 1'b0;
        end
    end

    // verdict of the field in progress, as time or as date
    always_comb begin
        cur_t_ok = (r_fcnt >= 4'd6) && !r_pair_bad && (r_pair[0] <= MAX_HOUR)
                   && (r_pair[1] <= MAX_MINSEC) && (r_pair[2] <= MAX_MINSEC)
                   && (!r_dot || (r_frac_len >= 3'd1 && r_frac_len <= 3'd3 && !r_frac_bad));
        if (!r_dot) begin
            cur_ms = 10'd0;
        end else if (r_frac_len == 3'd1) begin
            cur_ms = 10'((r_frac_val << 6) + (r_frac_val << 5) + (r_frac_val << 2));
        end else if (r_frac_len == 3'd2) begin
            cur_ms = 10'((r_frac_val << 3) + (r_frac_val << 1));
        end else begin
            cur_ms = r_frac_val;
        end
        cur_d_ok = (r_fcnt == 4'd6) && !r_pair_bad
                   && (r_pair[0] >= 7'd1) && (r_pair[0] <= MAX_DAY)
                   && (r_pair[1] >= 7'd1) && (r_pair[1] <= MAX_MONTH);
        cur_mo   = (r_pair[1] != 7'd0) ? r_pair[1] - 7'd1 : r_pair[1];
        cur_yy   = (r_pair[2] < YEAR_PIVOT) ? {1'b0, r_pair[2]} + CENTURY
                                            : {1'b0, r_pair[2]};
    end

    // next sentence state for the character in the input register
    always_comb begin
        is_dig     = (r_data >= CH_0) && (r_data <= CH_9);
        digit      = r_data[3:0];
        pair_cur   = r_pair[r_fcnt[2:1]];
        n_pos      = r_pos;
        n_hdr      = r_hdr;
        n_xor      = r_xor;
        n_xor_star = r_xor_star;
        n_star     = r_star;
        n_cas      = r_cas;
        n_rsum     = r_rsum;
        n_hex_ok   = r_hex_ok;
        n_fidx     = r_fidx;
        n_fcnt     = r_fcnt;
        n_pair     = r_pair;
        n_pair_bad = r_pair_bad;
        n_dot      = r_dot;
        n_frac_bad = r_frac_bad;
        n_frac_len = r_frac_len;
        n_frac_val = r_frac_val;
        n_commit   = r_commit;
        n_at_star  = r_at_star;

        // header capture
        if (r_pos < 3'(HDR_LEN)) begin
            n_hdr[r_pos] = r_data;
            n_pos        = r_pos + 3'd1;
        end

        // checksum digits after the last star
        if (r_data == CH_STAR) begin
            n_xor_star = r_xor;
            n_star     = 1'b1;
            n_cas      = 2'd0;
            n_rsum     = 8'd0;
            n_hex_ok   = 1'b1;
            n_at_star  = r_commit;
            if (r_fidx == FIELD_TIME) begin
                n_at_star.t_ok = cur_t_ok;
                n_at_star.hh   = r_pair[0][4:0];
                n_at_star.mi   = r_pair[1][5:0];
                n_at_star.ss   = r_pair[2][5:0];
                n_at_star.ms   = cur_ms;
            end else if (r_fidx == FIELD_DATE) begin
                n_at_star.d_ok = cur_d_ok;
                n_at_star.dd   = r_pair[0][4:0];
                n_at_star.mo   = cur_mo[3:0];
                n_at_star.yy   = cur_yy;
            end
        end else if (r_star) begin
            if (r_cas < 2'd2) begin
                if (!hex_good) begin
                    n_hex_ok = 1'b0;
                end else begin
                    n_rsum = {r_rsum[3:0], hex_val};
                end
            end
            if (r_cas != 2'd3) begin
                n_cas = r_cas + 2'd1;
            end
        end

        // running checksum skips the first character
        if (r_pos != 3'd0) begin
            n_xor = r_xor ^ r_data;
        end

        // field split on comma, else feed the field parser
        if (r_data == CH_COMMA) begin
            if (r_fidx == FIELD_TIME) begin
                n_commit.t_ok = cur_t_ok;
                n_commit.hh   = r_pair[0][4:0];
                n_commit.mi   = r_pair[1][5:0];
                n_commit.ss   = r_pair[2][5:0];
                n_commit.ms   = cur_ms;
            end else if (r_fidx == FIELD_DATE) begin
                n_commit.d_ok = cur_d_ok;
                n_commit.dd   = r_pair[0][4:0];
                n_commit.mo   = cur_mo[3:0];
                n_commit.yy   = cur_yy;
            end
            if (r_fidx != 5'd31) begin
                n_fidx = r_fidx + 5'd1;
            end
            n_fcnt     = 4'd0;
            n_pair[0]  = 7'd0;
            n_pair[1]  = 7'd0;
            n_pair[2]  = 7'd0;
            n_pair_bad = 1'b0;
            n_dot      = 1'b0;
            n_frac_bad = 1'b0;
            n_frac_len = 3'd0;
            n_frac_val = 10'd0;
        end else begin
            if (r_fcnt < 4'd6) begin
                if (is_dig) begin
                    n_pair[r_fcnt[2:1]] = 7'((pair_cur << 3) + (pair_cur << 1))
                                          + {3'd0, digit};
                end else begin
                    n_pair_bad = 1'b1;
                end
            end else if (!r_dot) begin
                if (r_data == CH_DOT) begin
                    n_dot = 1'b1;
                end
            end else begin
                if (!is_dig) begin
                    n_frac_bad = 1'b1;
                end else if (r_frac_len < 3'd3) begin
                    n_frac_val = 10'((r_frac_val << 3) + (r_frac_val << 1))
                                 + {6'd0, digit};
                end
                if (r_frac_len < 3'd4) begin
                    n_frac_len = r_frac_len + 3'd1;
                end
            end
            if (r_fcnt != 4'd15) begin
                n_fcnt = r_fcnt + 4'd1;
            end
        end
    end

    // verdict from the state after this character
    always_comb begin
        n_type = TYPE_UNKNOWN;
        n_talk = TALK_UNKNOWN;
        hdr_ok = (n_pos == 3'(HDR_LEN)) && (n_hdr[0] == CH_DOLLAR);
        if (hdr_ok) begin
            if (n_hdr[1] == CH_UG) begin
                if (n_hdr[2] == CH_UP) begin
                    n_talk = TALK_GP;
                end else if (n_hdr[2] == CH_UL) begin
                    n_talk = TALK_GL;
                end else if (n_hdr[2] == CH_UN) begin
                    n_talk = TALK_GN;
                end
            end
            if (n_hdr[3] == CH_UG && n_hdr[4] == CH_UG && n_hdr[5] == CH_UA) begin
                n_type = TYPE_GGA;
            end else if (n_hdr[3] == CH_UG && n_hdr[4] == CH_US && n_hdr[5] == CH_UA) begin
                n_type = TYPE_GSA;
            end else if (n_hdr[3] == CH_UG && n_hdr[4] == CH_US && n_hdr[5] == CH_UV) begin
                n_type = TYPE_GSV;
            end else if (n_hdr[3] == CH_UR && n_hdr[4] == CH_UM && n_hdr[5] == CH_UC) begin
                n_type = TYPE_RMC;
            end
        end

        case (n_type)
            TYPE_GGA: type_on = r_type_enable[0];
            TYPE_GSA: type_on = r_type_enable[1];
            TYPE_GSV: type_on = r_type_enable[2];
            TYPE_RMC: type_on = r_type_enable[3];
            default:  type_on = 1'b0;
        endcase

        if (n_type == TYPE_UNKNOWN || n_talk == TALK_UNKNOWN) begin
            n_reason = RSN_BAD_HEADER;
        end else if (!type_on) begin
            n_reason = RSN_TYPE_OFF;
        end else if (!n_star) begin
            n_reason = RSN_NO_STAR;
        end else if (n_cas < 2'd2 || !n_hex_ok || n_rsum != n_xor_star) begin
            n_reason = RSN_BAD_CHECKSUM;
        end else begin
            n_reason = RSN_ACCEPTED;
        end

        n_res = '0;
        if (n_reason == RSN_ACCEPTED && (n_type == TYPE_GGA || n_type == TYPE_RMC)
            && n_at_star.t_ok) begin
            n_res.t_ok = 1'b1;
            n_res.hh   = n_at_star.hh;
            n_res.mi   = n_at_star.mi;
            n_res.ss   = n_at_star.ss;
            n_res.ms   = n_at_star.ms;
            if (n_type == TYPE_RMC && n_at_star.d_ok) begin
                n_res.d_ok = 1'b1;
                n_res.dd   = n_at_star.dd;
                n_res.mo   = n_at_star.mo;
                n_res.yy   = n_at_star.yy;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_data <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_enable <= 4'hF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_type_enable <= i_cfg_type_enable;
        end
    end

    // sentence state, cleared after each verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_last)) begin
            r_pos      <= 3'd0;
            r_xor      <= 8'd0;
            r_xor_star <= 8'd0;
            r_star     <= 1'b0;
            r_cas      <= 2'd0;
            r_rsum     <= 8'd0;
            r_hex_ok   <= 1'b1;
            r_fidx     <= 5'd0;
            r_fcnt     <= 4'd0;
            r_pair[0]  <= 7'd0;
            r_pair[1]  <= 7'd0;
            r_pair[2]  <= 7'd0;
            r_pair_bad <= 1'b0;
            r_dot      <= 1'b0;
            r_frac_bad <= 1'b0;
            r_frac_len <= 3'd0;
            r_frac_val <= 10'd0;
            r_commit   <= '0;
            r_at_star  <= '0;
        end else if (advance) begin
            r_pos      <= n_pos;
            r_xor      <= n_xor;
            r_xor_star <= n_xor_star;
            r_star     <= n_star;
            r_cas      <= n_cas;
            r_rsum     <= n_rsum;
            r_hex_ok   <= n_hex_ok;
            r_fidx     <= n_fidx;
            r_fcnt     <= n_fcnt;
            r_pair     <= n_pair;
            r_pair_bad <= n_pair_bad;
            r_dot      <= n_dot;
            r_frac_bad <= n_frac_bad;
            r_frac_len <= n_frac_len;
            r_frac_val <= n_frac_val;
            r_commit   <= n_commit;
            r_at_star  <= n_at_star;
        end
    end

    // header characters hold no reset
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_hdr <= n_hdr;
        end
    end

    // verdict register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_last) begin
            r_type   <= n_type;
            r_talk   <= n_talk;
            r_reason <= n_reason;
            r_res    <= n_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sentence_type = r_type;
    assign o_talker_id     = r_talk;
    assign o_reject_reason = r_reason;
    assign o_time_ok       = r_res.t_ok;
    assign o_hour          = r_res.hh;
    assign o_minute        = r_res.mi;
    assign o_second        = r_res.ss;
    assign o_millisecond   = r_res.ms;
    assign o_date_ok       = r_res.d_ok;
    assign o_day           = r_res.dd;
    assign o_month         = r_res.mo;
    assign o_year          = r_res.yy;

endmodule

/* rtl/nmea_chk_sva.sv */
// Port checker of the NMEA sentence checker and its bind
`timescale 1ns / 1ps
module nmea_chk_sva
    import nmea_chk_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_data_byte,
    input logic       i_last_byte,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic [3:0] i_cfg_type_enable,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_sentence_type,
    input logic [1:0] o_talker_id,
    input logic [2:0] o_reject_reason,
    input logic       o_time_ok,
    input logic [4:0] o_hour,
    input logic [5:0] o_minute,
    input logic [5:0] o_second,
    input logic [9:0] o_millisecond,
    input logic       o_date_ok,
    input logic [4:0] o_day,
    input logic [3:0] o_month,
    input logic [7:0] o_year
);

    // a stalled verdict stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sentence_type)
            && $stable(o_reject_reason) && $stable(o_time_ok) && $stable(o_date_ok))
        else $error("verdict changed while stalled");

    // time only on an accepted GGA or RMC, and in range
    a_time_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_time_ok |-> o_reject_reason == RSN_ACCEPTED
            && (o_sentence_type == TYPE_GGA || o_sentence_type == TYPE_RMC)
            && o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59
            && o_millisecond <= 10'd999)
        else $error("time given on a sentence that cannot carry it");

    // date needs the time and an RMC sentence
    a_date_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_date_ok |-> o_time_ok && o_sentence_type == TYPE_RMC
            && o_day >= 5'd1 && o_day <= 5'd31 && o_month <= 4'd11)
        else $error("date given without time or outside RMC");

    // an unknown header always ends in a header reject
    a_bad_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_sentence_type == TYPE_UNKNOWN || o_talker_id == TALK_UNKNOWN)
            |-> o_reject_reason == RSN_BAD_HEADER && !o_time_ok && !o_date_ok)
        else $error("unknown header not rejected");

endmodule

bind nmea_sentence_checker nmea_chk_sva u_nmea_chk_sva (.*);
